@@ design/json_message_framer_unit_assert.svh @@
// assertion macros for the json message framer
`ifndef JSON_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`define JSON_MESSAGE_FRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define JMF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define JMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JMF_ASSERT_SAME(lbl, ante, cons, msg)
`define JMF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/jmf_pkg.sv @@
// shared types and constants of the json message framer
package jmf_pkg;

    localparam int unsigned MAX_DEPTH_DEF = 255;
    localparam logic [15:0] LIMIT_RESET   = 16'(16 * 1024);

    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_STRAY = 2'd1,
        ERR_LONG  = 2'd2,
        ERR_DEEP  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        keep;
        logic        end_of_message;
        logic [15:0] message_length;
        t_err        error_code;
    } t_result;

endpackage

@@ design/json_message_framer_unit.sv @@
// top level of the json message framer
// accepted byte: input register, then combinational parser, then result register (o_valid)
// one item per cycle unless i_ready stalls; framing state updates in the single parser pass
// ready stays high while the result register is free or being taken
// reset (synchronous, active low) clears framing state and errors, limit returns to 16384
module json_message_framer_unit #(
    parameter int unsigned MAX_DEPTH = jmf_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_keep,
    output logic        o_end_of_message,
    output logic [15:0] o_message_length,
    output logic [1:0]  o_error_code
);
    import jmf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_valid;
    logic       adv;
    t_result    res_d;
    t_result    res_q;

    assign adv     = r_in_valid && (!out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    jmf_parser #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_adv        (adv),
        .i_byte       (r_in_byte),
        .o_res        (res_d)
    );

    jmf_result_reg u_result (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (adv),
        .i_res  (res_d),
        .i_take (i_ready),
        .o_valid(out_valid),
        .o_res  (res_q)
    );

    assign o_valid          = out_valid;
    assign o_out_byte       = res_q.out_byte;
    assign o_keep           = res_q.keep;
    assign o_end_of_message = res_q.end_of_message;
    assign o_message_length = res_q.message_length;
    assign o_error_code     = res_q.error_code;

endmodule

@@ design/jmf_parser.sv @@
// framing state and per-item next-state logic
`include "json_message_framer_unit_assert.svh"

module jmf_parser #(
    parameter int unsigned MAX_DEPTH = jmf_pkg::MAX_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    output jmf_pkg::t_result o_res
);
    import jmf_pkg::*;

    localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    logic [15:0]        r_max_len;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_in_str, n_in_str;
    logic               r_after_bs, n_after_bs;
    logic               r_swallow, n_swallow;
    logic [15:0]        r_len, n_len;
    t_err               r_err, n_err;

    always_comb begin
        logic fault;
        logic brace_end;
        fault      = 1'b0;
        brace_end  = 1'b0;
        n_depth    = r_depth;
        n_in_str   = r_in_str;
        n_after_bs = r_after_bs;
        n_swallow  = 1'b0;
        n_len      = r_len;
        n_err      = r_err;
        o_res.out_byte       = i_byte;
        o_res.keep           = 1'b0;
        o_res.end_of_message = 1'b0;
        o_res.message_length = r_len;
        if (r_err != ERR_NONE) begin
            o_res.message_length = r_len;
        end else if (i_byte == CH_NL) begin
            if (r_swallow) begin
                o_res.message_length = 16'd0;
            end else begin
                o_res.end_of_message = 1'b1;
                o_res.message_length = r_len;
            end
            n_depth    = '0;
            n_in_str   = 1'b0;
            n_after_bs = 1'b0;
            n_len      = 16'd0;
        end else begin
            if (r_in_str) begin
                if (r_after_bs) begin
                    n_after_bs = 1'b0;
                end else if (i_byte == CH_BSLASH) begin
                    n_after_bs = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    n_in_str = 1'b0;
                end
            end else if (i_byte == CH_QUOTE) begin
                n_in_str = 1'b1;
            end else if (i_byte == CH_OPEN) begin
                if (r_depth >= DEPTH_MAX) begin
                    n_err = ERR_DEEP;
                    fault = 1'b1;
                end else begin
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end else if (i_byte == CH_CLOSE) begin
                if (r_depth == '0) begin
                    n_err = ERR_STRAY;
                    fault = 1'b1;
                end else begin
                    n_depth = r_depth - DEPTH_W'(1);
                    brace_end = (r_depth == DEPTH_W'(1));
                end
            end
            if (!fault) begin
                o_res.keep           = 1'b1;
                o_res.message_length = r_len + 16'd1;
                n_len                = r_len + 16'd1;
                if (brace_end) begin
                    o_res.end_of_message = 1'b1;
                    n_depth    = '0;
                    n_in_str   = 1'b0;
                    n_after_bs = 1'b0;
                    n_len      = 16'd0;
                    n_swallow  = 1'b1;
                end else if (n_len >= r_max_len) begin
                    n_err = ERR_LONG;
                end
            end
        end
        o_res.error_code = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= LIMIT_RESET;
            r_depth    <= '0;
            r_in_str   <= 1'b0;
            r_after_bs <= 1'b0;
            r_swallow  <= 1'b0;
            r_len      <= 16'd0;
            r_err      <= ERR_NONE;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (i_adv) begin
                r_depth    <= n_depth;
                r_in_str   <= n_in_str;
                r_after_bs <= n_after_bs;
                r_swallow  <= n_swallow;
                r_len      <= n_len;
                r_err      <= n_err;
            end
        end
    end

    `JMF_ASSERT_NEXT(a_err_sticky, r_err != ERR_NONE, r_err == $past(r_err), "error code changed")
    `JMF_ASSERT_SAME(a_escape_in_str, !r_in_str, !r_after_bs, "escape flag outside string")
    `JMF_ASSERT_NEXT(a_eom_clears, i_adv && o_res.end_of_message, r_depth == '0 && r_len == 16'd0, "message end left state")

endmodule

@@ design/jmf_result_reg.sv @@
// output register holding one finished result item
module jmf_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jmf_pkg::t_result i_res,
    input  logic             i_take,
    output logic             o_valid,
    output jmf_pkg::t_result o_res
);
    import jmf_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
